[hw/rtl/rltc_pkg.sv]
// shared types, register indexes and calendar helpers for the local time converter
package rltc_pkg;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_BCD_MODE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOUR_24_MODE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_HOURS   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_MINUTES = 2'd3;

   localparam logic [11:0] YEAR_BASE = 12'd2000;

   // depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // one classified transaction, minute carry already applied
   typedef struct packed {
      logic [5:0]        seconds;
      logic [5:0]        minutes;
      logic signed [8:0] hours;
      logic [7:0]        weekday;
      logic [7:0]        day;
      logic [7:0]        month;
      logic [7:0]        year_byte;
      logic              leap;
      logic              hour_24;
      logic              pm;
      logic              range_err;
   } rltc_item_type;

   // one finished result
   typedef struct packed {
      logic [5:0]  local_seconds;
      logic [5:0]  local_minutes;
      logic [4:0]  local_hours;
      logic [2:0]  local_weekday;
      logic [4:0]  local_day;
      logic [3:0]  local_month;
      logic [11:0] local_year;
      logic        was_24hour;
      logic        chip_pm;
      logic        range_error;
   } rltc_result_type;

   // packed bcd or plain binary byte
   function automatic logic [7:0] decode_byte(input logic [7:0] b, input logic bcd);
      logic [7:0] hi;
      hi = {4'd0, b[7:4]};
      return bcd ? ((hi << 3) + (hi << 1) + {4'd0, b[3:0]}) : b;
   endfunction

   // days in a month, invalid months count as 31
   function automatic logic [4:0] month_days(input logic [7:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         8'd2:                      len = leap ? 5'd29 : 5'd28;
         8'd4, 8'd6, 8'd9, 8'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[hw/rtl/rtc_local_time_convert_core.sv]
// top level of the clock-chip snapshot to local time converter
//
// A transaction (one snapshot of the seven raw clock-chip time bytes) is taken
// at every rising edge with start high and busy low, one per clock cycle. Its
// result appears on the rsp_ ports after the queue and the output register, for one cycle,
// marked by rsp_strobe; the receiver cannot stall it, so it must sample then.
// The front end (decode, range check, minute carry) writes the queue
// in the accept cycle and the back end (hour carry and calendar
// rollover) drains it into the output register the next cycle.
// Since the back end drains the queue every cycle, busy stays low in normal
// operation. Configuration writes through csr_ take effect on the next edge
// and must only be made while no transaction is in flight.
module rtc_local_time_convert_core (
   input  logic                              clock,
   input  logic                              reset,
   // request transaction
   input  logic                              start,
   output logic                              busy,
   input  logic [7:0]                        req_raw_seconds,
   input  logic [7:0]                        req_raw_minutes,
   input  logic [7:0]                        req_raw_hours,
   input  logic [7:0]                        req_raw_weekday,
   input  logic [7:0]                        req_raw_day,
   input  logic [7:0]                        req_raw_month,
   input  logic [7:0]                        req_raw_year,
   // configuration writes
   input  logic                              csr_we,
   input  logic [rltc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rltc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // result transaction
   output logic                              rsp_strobe,
   output logic [5:0]                        rsp_local_seconds,
   output logic [5:0]                        rsp_local_minutes,
   output logic [4:0]                        rsp_local_hours,
   output logic [2:0]                        rsp_local_weekday,
   output logic [4:0]                        rsp_local_day,
   output logic [3:0]                        rsp_local_month,
   output logic [11:0]                       rsp_local_year,
   output logic                              rsp_was_24hour,
   output logic                              rsp_chip_pm,
   output logic                              rsp_range_error
);
   import rltc_pkg::*;

   rltc_item_type   front_item;
   rltc_item_type   head_item;
   rltc_result_type result;
   logic            accept;
   logic            queue_full;
   logic            queue_not_empty;

   // take a transaction whenever the queue has room
   assign busy   = queue_full;
   assign accept = start && !queue_full;

   // decode and classify the snapshot with the current configuration
   rltc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .raw_seconds (req_raw_seconds),
      .raw_minutes (req_raw_minutes),
      .raw_hours   (req_raw_hours),
      .raw_weekday (req_raw_weekday),
      .raw_day     (req_raw_day),
      .raw_month   (req_raw_month),
      .raw_year    (req_raw_year),
      .item        (front_item)
   );

   // decouples front and back
   rltc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (queue_not_empty),
      .head_item (head_item),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // back end pops whenever something is queued, never stalled by the receiver
   rltc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (queue_not_empty),
      .item          (head_item),
      .result_strobe (rsp_strobe),
      .result        (result)
   );

   assign rsp_local_seconds = result.local_seconds;
   assign rsp_local_minutes = result.local_minutes;
   assign rsp_local_hours   = result.local_hours;
   assign rsp_local_weekday = result.local_weekday;
   assign rsp_local_day     = result.local_day;
   assign rsp_local_month   = result.local_month;
   assign rsp_local_year    = result.local_year;
   assign rsp_was_24hour    = result.was_24hour;
   assign rsp_chip_pm       = result.chip_pm;
   assign rsp_range_error   = result.range_error;

   // every accepted transaction comes out through the queue and the output register
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted transaction gave no result after two cycles");

   // no result without a matching transaction accepted earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result strobe without matching transaction");

   // back end keeps up, so the queue never fills
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("queue filled up");

endmodule

[hw/rtl/rltc_front.sv]
// front end: configuration registers, byte decode, range check and minute carry
module rltc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rltc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rltc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [7:0]                        raw_seconds,
   input  logic [7:0]                        raw_minutes,
   input  logic [7:0]                        raw_hours,
   input  logic [7:0]                        raw_weekday,
   input  logic [7:0]                        raw_day,
   input  logic [7:0]                        raw_month,
   input  logic [7:0]                        raw_year,
   output rltc_pkg::rltc_item_type           item
);
   import rltc_pkg::*;

   logic       bcd_mode_ff, bcd_mode_in;
   logic       hour_24_mode_ff, hour_24_mode_in;
   logic [4:0] offset_hours_ff, offset_hours_in;
   logic [6:0] offset_minutes_ff, offset_minutes_in;

   logic [7:0]        sec, min, hr_raw, hr, wd, day, mon, ybyte;
   logic              pm, leap, err;
   logic signed [9:0] min_sum;
   logic signed [8:0] hr_sum;
   logic signed [9:0] min_adj;
   logic signed [8:0] hr_adj;

   always_comb begin
      bcd_mode_in       = bcd_mode_ff;
      hour_24_mode_in   = hour_24_mode_ff;
      offset_hours_in   = offset_hours_ff;
      offset_minutes_in = offset_minutes_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BCD_MODE:       bcd_mode_in       = csr_wdata[0];
            CSR_HOUR_24_MODE:   hour_24_mode_in   = csr_wdata[0];
            CSR_OFFSET_HOURS:   offset_hours_in   = csr_wdata[4:0];
            CSR_OFFSET_MINUTES: offset_minutes_in = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcd_mode_ff       <= 1'b0;
         hour_24_mode_ff   <= 1'b1;
         offset_hours_ff   <= 5'd5;
         offset_minutes_ff <= 7'd30;
      end else begin
         bcd_mode_ff       <= bcd_mode_in;
         hour_24_mode_ff   <= hour_24_mode_in;
         offset_hours_ff   <= offset_hours_in;
         offset_minutes_ff <= offset_minutes_in;
      end
   end

   always_comb begin
      sec    = decode_byte(raw_seconds, bcd_mode_ff);
      min    = decode_byte(raw_minutes, bcd_mode_ff);
      hr_raw = decode_byte({1'b0, raw_hours[6:0]}, bcd_mode_ff);
      wd     = decode_byte(raw_weekday, bcd_mode_ff);
      day    = decode_byte(raw_day, bcd_mode_ff);
      mon    = decode_byte(raw_month, bcd_mode_ff);
      ybyte  = decode_byte(raw_year, bcd_mode_ff);

      // 12-hour mapping: pm adds 12 except at 12, am 12 is midnight
      hr = hr_raw;
      if (!hour_24_mode_ff) begin
         pm = raw_hours[7];
         if (pm && hr_raw != 8'd12) hr = hr_raw + 8'd12;
         else if (!pm && hr_raw == 8'd12) hr = 8'd0;
      end else begin
         pm = (hr_raw >= 8'd12);
      end

      // years 2000..2255: only 2100 and 2200 are century non-leap years
      leap = (ybyte[1:0] == 2'b00) && (ybyte != 8'd100) && (ybyte != 8'd200);

      err = (sec > 8'd59) || (min > 8'd59) || (hr > 8'd23) ||
            (wd < 8'd1) || (wd > 8'd7) || (mon < 8'd1) || (mon > 8'd12) ||
            (ybyte > 8'd99) || (day < 8'd1) ||
            (day > {3'd0, month_days(mon, leap)});

      min_sum = $signed({2'b00, min}) + $signed({{3{offset_minutes_ff[6]}}, offset_minutes_ff});
      hr_sum  = $signed({1'b0, hr}) + $signed({{4{offset_hours_ff[4]}}, offset_hours_ff});

      // single minute carry step
      min_adj = min_sum;
      hr_adj  = hr_sum;
      if (min_sum >= 10'sd60) begin
         min_adj = min_sum - 10'sd60;
         hr_adj  = hr_sum + 9'sd1;
      end else if (min_sum < 10'sd0) begin
         min_adj = min_sum + 10'sd60;
         hr_adj  = hr_sum - 9'sd1;
      end

      item.seconds   = sec[5:0];
      item.minutes   = min_adj[5:0];
      item.hours     = hr_adj;
      item.weekday   = wd;
      item.day       = day;
      item.month     = mon;
      item.year_byte = ybyte;
      item.leap      = leap;
      item.hour_24   = hour_24_mode_ff;
      item.pm        = pm;
      item.range_err = err;
   end

endmodule

[hw/rtl/rltc_queue.sv]
// short queue of classified transactions between front and back
module rltc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rltc_pkg::rltc_item_type  push_item,
   input  logic                     pop,
   output rltc_pkg::rltc_item_type  head_item,
   output logic                     not_empty,
   output logic                     full
);
   import rltc_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   rltc_item_type    entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

[hw/rtl/rltc_back.sv]
// back end: hour carry, day, month, year and weekday rollover, output register
module rltc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  rltc_pkg::rltc_item_type   item,
   output logic                      result_strobe,
   output rltc_pkg::rltc_result_type result
);
   import rltc_pkg::*;

   logic            strobe_ff, strobe_in;
   rltc_result_type result_ff, result_in;

   logic signed [8:0] hr;
   logic [8:0]        day_n, mon_n, wd_n;
   logic [7:0]        mon_prev;
   logic [11:0]       year_n;
   logic [4:0]        cur_len;

   always_comb begin
      hr      = item.hours;
      day_n   = {1'b0, item.day};
      mon_n   = {1'b0, item.month};
      wd_n    = {1'b0, item.weekday};
      year_n  = YEAR_BASE + {4'd0, item.year_byte};
      cur_len = month_days(item.month, item.leap);
      mon_prev = item.month;

      if (hr >= 9'sd24) begin
         hr    = item.hours - 9'sd24;
         day_n = {1'b0, item.day} + 9'd1;
         if (day_n > {4'd0, cur_len}) begin
            day_n = 9'd1;
            mon_n = {1'b0, item.month} + 9'd1;
            if (mon_n > 9'd12) begin
               mon_n  = 9'd1;
               year_n = year_n + 12'd1;
            end
         end
         wd_n = {1'b0, item.weekday} + 9'd1;
         if (wd_n > 9'd7) wd_n = 9'd1;
      end else if (hr < 9'sd0) begin
         hr = item.hours + 9'sd24;
         if (item.day <= 8'd1) begin
            // borrow from the previous month
            if (item.month <= 8'd1) begin
               mon_prev = 8'd12;
               year_n   = year_n - 12'd1;
            end else begin
               mon_prev = item.month - 8'd1;
            end
            mon_n = {1'b0, mon_prev};
            day_n = {4'd0, month_days(mon_prev, item.leap)};
         end else begin
            day_n = {1'b0, item.day} - 9'd1;
         end
         wd_n = (item.weekday <= 8'd1) ? 9'd7 : ({1'b0, item.weekday} - 9'd1);
      end

      strobe_in                = item_valid;
      result_in.local_seconds  = item.seconds;
      result_in.local_minutes  = item.minutes;
      result_in.local_hours    = hr[4:0];
      result_in.local_weekday  = wd_n[2:0];
      result_in.local_day      = day_n[4:0];
      result_in.local_month    = mon_n[3:0];
      result_in.local_year     = year_n;
      result_in.was_24hour     = item.hour_24;
      result_in.chip_pm        = item.pm;
      result_in.range_error    = item.range_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         result_ff <= result_in;
      end
   end

   assign result_strobe = strobe_ff;
   assign result        = result_ff;

endmodule

[dv/tb_rtc_local_time_convert_core.sv]
// self-checking testbench for the clock-chip snapshot to local time converter
`timescale 1ns / 1ps

module tb_rtc_local_time_convert_core;
   import rltc_pkg::*;

   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned ITEMS_PER_PHASE = 75;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   // results pass the queue and the output register, leave a little margin on top
   localparam int unsigned DRAIN_CYCLES    = 4;

   // one snapshot of the seven raw clock-chip bytes
   typedef struct packed {
      logic [7:0] seconds;
      logic [7:0] minutes;
      logic [7:0] hours;
      logic [7:0] weekday;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
   } rtc_snapshot_type;

   // dut connections, every input known from time zero
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   start      = 1'b0;
   logic                   busy;
   rtc_snapshot_type       drive_snap = '0;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   rsp_strobe;
   logic [5:0]             rsp_local_seconds;
   logic [5:0]             rsp_local_minutes;
   logic [4:0]             rsp_local_hours;
   logic [2:0]             rsp_local_weekday;
   logic [4:0]             rsp_local_day;
   logic [3:0]             rsp_local_month;
   logic [11:0]            rsp_local_year;
   logic                   rsp_was_24hour;
   logic                   rsp_chip_pm;
   logic                   rsp_range_error;

   // testbench copy of the configuration registers, reset values
   logic       cfg_bcd   = 1'b0;
   logic       cfg_h24   = 1'b1;
   logic [4:0] cfg_off_h = 5'd5;
   logic [6:0] cfg_off_m = 7'd30;

   rtc_snapshot_type pending_snapshots[$];
   rltc_result_type  expected_local_times[$];
   rltc_result_type  expected_now;

   int gap_left        = 0;
   int burst_left      = 1;
   int stall_cycles    = 0;
   int mismatch_count  = 0;
   int items_accepted  = 0;
   int results_checked = 0;
   int settings_count  = 1;

   rtc_local_time_convert_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_raw_seconds   (drive_snap.seconds),
      .req_raw_minutes   (drive_snap.minutes),
      .req_raw_hours     (drive_snap.hours),
      .req_raw_weekday   (drive_snap.weekday),
      .req_raw_day       (drive_snap.day),
      .req_raw_month     (drive_snap.month),
      .req_raw_year      (drive_snap.year),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_strobe        (rsp_strobe),
      .rsp_local_seconds (rsp_local_seconds),
      .rsp_local_minutes (rsp_local_minutes),
      .rsp_local_hours   (rsp_local_hours),
      .rsp_local_weekday (rsp_local_weekday),
      .rsp_local_day     (rsp_local_day),
      .rsp_local_month   (rsp_local_month),
      .rsp_local_year    (rsp_local_year),
      .rsp_was_24hour    (rsp_was_24hour),
      .rsp_chip_pm       (rsp_chip_pm),
      .rsp_range_error   (rsp_range_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // calendar prediction
   // ---------------------------------------------------------------------

   // packed bcd or plain binary, as currently configured
   function automatic int decode_raw(input logic [7:0] b);
      return cfg_bcd ? int'(b[7:4]) * 10 + int'(b[3:0]) : int'(b);
   endfunction

   // inverse of decode_raw for in-range values, used to build snapshots
   function automatic logic [7:0] encode_value(input int v);
      return cfg_bcd ? {4'(v / 10), 4'(v % 10)} : 8'(v);
   endfunction

   function automatic bit is_leap_year(input int y);
      return (y % 4 == 0) && (y % 100 != 0 || y % 400 == 0);
   endfunction

   // an invalid month is treated as a 31-day month
   function automatic int month_length(input int mon, input int year);
      if (mon < 1 || mon > 12)
         return 31;
      case (mon)
         2:           return is_leap_year(year) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic rltc_result_type convert_snapshot(input rtc_snapshot_type s);
      int              sec, mins, hr, wd, day, mon, ybyte, year, oh, om;
      logic            pm, err;
      rltc_result_type r;
      sec   = decode_raw(s.seconds);
      mins  = decode_raw(s.minutes);
      // bit 7 of the hours byte is kept out of the decoded hour; in 12-hour mode it is the pm flag
      hr    = decode_raw({1'b0, s.hours[6:0]});
      wd    = decode_raw(s.weekday);
      day   = decode_raw(s.day);
      mon   = decode_raw(s.month);
      ybyte = decode_raw(s.year);
      year  = ybyte + 2000;

      // 12-hour mapping: pm adds 12 except at 12, 12 am becomes 0
      if (!cfg_h24) begin
         pm = s.hours[7];
         if (pm && hr != 12)
            hr += 12;
         else if (!pm && hr == 12)
            hr = 0;
      end else begin
         pm = (hr >= 12);
      end

      err = sec > 59 || mins > 59 || hr > 23 || wd < 1 || wd > 7 ||
            mon < 1 || mon > 12 || ybyte > 99 ||
            day < 1 || day > month_length(mon, year);

      om = $signed(cfg_off_m);
      oh = $signed(cfg_off_h);
      mins += om;
      hr   += oh;
      // a single carry step each for minutes and hours
      if (mins >= 60) begin
         mins -= 60;
         hr++;
      end else if (mins < 0) begin
         mins += 60;
         hr--;
      end

      if (hr >= 24) begin
         hr -= 24;
         day++;
         if (day > month_length(mon, year)) begin
            day = 1;
            mon++;
            if (mon > 12) begin
               mon = 1;
               year++;
            end
         end
         wd++;
         if (wd > 7)
            wd = 1;
      end else if (hr < 0) begin
         hr += 24;
         day--;
         if (day < 1) begin
            mon--;
            if (mon < 1) begin
               mon = 12;
               year--;
            end
            // length taken after the year has stepped back
            day = month_length(mon, year);
         end
         wd--;
         if (wd < 1)
            wd = 7;
      end

      r.local_seconds = 6'(sec);
      r.local_minutes = 6'(mins);
      r.local_hours   = 5'(hr);
      r.local_weekday = 3'(wd);
      r.local_day     = 5'(day);
      r.local_month   = 4'(mon);
      r.local_year    = 12'(year);
      r.was_24hour    = cfg_h24;
      r.chip_pm       = pm;
      r.range_error   = err;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   task automatic push_snapshot(input logic [7:0] sec, input logic [7:0] mins,
                                input logic [7:0] hrs, input logic [7:0] wd,
                                input logic [7:0] day, input logic [7:0] mon,
                                input logic [7:0] yr);
      pending_snapshots.push_back('{sec, mins, hrs, wd, day, mon, yr});
   endtask

   // mostly well-formed calendar times biased to the rollover edges,
   // the rest fully random bytes or one corrupted field
   function automatic rtc_snapshot_type gen_snapshot();
      rtc_snapshot_type s;
      int               kind, yb, mon, day, hr, mins, len, h12;
      kind = $urandom_range(0, 99);
      yb   = $urandom_range(0, 99);
      mon  = $urandom_range(1, 12);
      len  = month_length(mon, 2000 + yb);
      case ($urandom_range(0, 3))
         0:       day = 1;
         1:       day = len;
         default: day = $urandom_range(1, len);
      endcase
      case ($urandom_range(0, 3))
         0:       hr = 0;
         1:       hr = 23;
         default: hr = $urandom_range(0, 23);
      endcase
      case ($urandom_range(0, 3))
         0:       mins = 0;
         1:       mins = 59;
         default: mins = $urandom_range(0, 59);
      endcase
      s.seconds = encode_value($urandom_range(0, 59));
      s.minutes = encode_value(mins);
      s.weekday = encode_value($urandom_range(1, 7));
      s.day     = encode_value(day);
      s.month   = encode_value(mon);
      s.year    = encode_value(yb);
      if (cfg_h24) begin
         s.hours = encode_value(hr);
      end else begin
         h12     = (hr % 12 == 0) ? 12 : hr % 12;
         s.hours = encode_value(h12) | ((hr >= 12) ? 8'h80 : 8'h00);
      end

      if (kind < 15) begin
         s = 56'({$urandom(), $urandom()});
      end else if (kind < 25) begin
         case ($urandom_range(0, 6))
            0:       s.seconds = 8'($urandom());
            1:       s.minutes = 8'($urandom());
            2:       s.hours   = 8'($urandom());
            3:       s.weekday = 8'($urandom());
            4:       s.day     = 8'($urandom());
            5:       s.month   = 8'($urandom());
            default: s.year    = 8'($urandom());
         endcase
      end
      return s;
   endfunction

   // write lands at the edge where the task lowers csr_we, mirror copy is updated there too
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BCD_MODE:       cfg_bcd   = data[0];
         CSR_HOUR_24_MODE:   cfg_h24   = data[0];
         CSR_OFFSET_HOURS:   cfg_off_h = data[4:0];
         CSR_OFFSET_MINUTES: cfg_off_m = data[6:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [6:0] bcd_word, input logic [6:0] h24_word,
                                 input logic [6:0] hours_word, input logic [6:0] minutes_word);
      write_csr(CSR_BCD_MODE, bcd_word);
      write_csr(CSR_HOUR_24_MODE, h24_word);
      write_csr(CSR_OFFSET_HOURS, hours_word);
      write_csr(CSR_OFFSET_MINUTES, minutes_word);
      settings_count++;
   endtask

   // random modes and offsets, extremes favored; unused upper data bits
   // carry noise that the block should drop
   task automatic apply_random_settings();
      int         oh, om;
      logic [6:0] hours_word, minutes_word;
      case ($urandom_range(0, 4))
         0:       oh = -12;
         1:       oh = 14;
         2:       oh = 0;
         default: oh = int'($urandom_range(0, 26)) - 12;
      endcase
      case ($urandom_range(0, 4))
         0:       om = -59;
         1:       om = 59;
         2:       om = 0;
         default: om = int'($urandom_range(0, 118)) - 59;
      endcase
      hours_word   = ($urandom_range(0, 5) == 0) ? 7'($urandom()) : {2'($urandom()), 5'(oh)};
      minutes_word = ($urandom_range(0, 5) == 0) ? 7'($urandom()) : 7'(om);
      apply_settings({6'($urandom()), 1'($urandom())}, {6'($urandom()), 1'($urandom())},
                     hours_word, minutes_word);
   endtask

   // sampled on the falling edge so every nonblocking update has settled
   task automatic wait_until_drained();
      @(negedge clock);
      while (pending_snapshots.size() != 0 || start || expected_local_times.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // driver: bursts of transactions separated by random gaps
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_local_times.push_back(convert_snapshot(drive_snap));
            items_accepted++;
         end
         // a presented transaction stays put while busy holds it off
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_snapshots.size() != 0) begin
               drive_snap <= pending_snapshots.pop_front();
               start      <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                          : $urandom_range(1, 30);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: every strobed result against the oldest expectation
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [11:0] exp_v,
                              input logic [11:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_local_times.size() == 0) begin
            $error("result strobe with no transaction outstanding");
            mismatch_count++;
         end else begin
            expected_now = expected_local_times.pop_front();
            check_field("local_seconds", expected_now.local_seconds, rsp_local_seconds);
            check_field("local_minutes", expected_now.local_minutes, rsp_local_minutes);
            check_field("local_hours", expected_now.local_hours, rsp_local_hours);
            check_field("local_weekday", expected_now.local_weekday, rsp_local_weekday);
            check_field("local_day", expected_now.local_day, rsp_local_day);
            check_field("local_month", expected_now.local_month, rsp_local_month);
            check_field("local_year", expected_now.local_year, rsp_local_year);
            check_field("was_24hour", expected_now.was_24hour, rsp_was_24hour);
            check_field("chip_pm", expected_now.chip_pm, rsp_chip_pm);
            check_field("range_error", expected_now.range_error, rsp_range_error);
            results_checked++;
         end
      end
   end

   // watchdog: too long without any transaction, result or register write
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", stall_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      int p, i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: binary, 24-hour, +5:30
      push_snapshot(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      push_snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      // new year's eve rolls into 2100
      push_snapshot(8'd59, 8'd59, 8'd23, 8'd7, 8'd31, 8'd12, 8'd99);
      // end of february, common and leap year
      push_snapshot(8'd0, 8'd0, 8'd20, 8'd3, 8'd28, 8'd2, 8'd23);
      push_snapshot(8'd0, 8'd0, 8'd20, 8'd3, 8'd28, 8'd2, 8'd24);
      // feb 29 in a common year, in 2000, and in 2100 (not a leap year)
      push_snapshot(8'd10, 8'd10, 8'd10, 8'd4, 8'd29, 8'd2, 8'd23);
      push_snapshot(8'd10, 8'd10, 8'd10, 8'd4, 8'd29, 8'd2, 8'd0);
      push_snapshot(8'd10, 8'd10, 8'd10, 8'd4, 8'd29, 8'd2, 8'd100);
      // every field but the year just past its range, invalid month rolls as 31 days
      push_snapshot(8'd60, 8'd60, 8'd24, 8'd8, 8'd32, 8'd13, 8'd99);
      // pm flag boundary in 24-hour mode
      push_snapshot(8'd0, 8'd0, 8'd12, 8'd1, 8'd15, 8'd6, 8'd50);
      push_snapshot(8'd0, 8'd0, 8'd11, 8'd1, 8'd15, 8'd6, 8'd50);
      wait_until_drained();

      // bcd, 24-hour, largest in-range offsets
      apply_settings(7'd1, 7'd1, {2'b00, 5'd14}, 7'd59);
      push_snapshot(8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12, 8'h99);
      // non-decimal nibbles decode past the calendar
      push_snapshot(8'h5A, 8'hFF, 8'h9F, 8'hF0, 8'h00, 8'h00, 8'hA0);
      // one minute either side of midnight after the offset
      push_snapshot(8'h00, 8'h00, 8'h09, 8'h02, 8'h30, 8'h04, 8'h21);
      push_snapshot(8'h00, 8'h01, 8'h09, 8'h02, 8'h30, 8'h04, 8'h21);
      wait_until_drained();

      // bcd, 12-hour, most negative in-range offsets
      apply_settings(7'd1, 7'd0, {2'b00, 5'(-12)}, 7'(-59));
      // 12 am on jan 1 2000 steps back into 1999
      push_snapshot(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h01, 8'h00);
      // 12 pm on mar 1 2024 steps back to feb 29
      push_snapshot(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h03, 8'h24);
      push_snapshot(8'h00, 8'h00, 8'h81, 8'h02, 8'h01, 8'h03, 8'h23);
      push_snapshot(8'h00, 8'h00, 8'h11, 8'h02, 8'h15, 8'h07, 8'h10);
      // hour 13 in 12-hour mode, am and pm
      push_snapshot(8'h00, 8'h00, 8'h13, 8'h02, 8'h15, 8'h07, 8'h10);
      push_snapshot(8'h00, 8'h00, 8'h93, 8'h02, 8'h15, 8'h07, 8'h10);
      wait_until_drained();

      // binary, 12-hour, offsets at the negative end of their encodings
      apply_settings(7'd0, 7'd0, {2'b00, 5'h10}, 7'h40);
      push_snapshot(8'd0, 8'd0, 8'h80, 8'd1, 8'd1, 8'd1, 8'd0);
      push_snapshot(8'd59, 8'd59, 8'h8C, 8'd7, 8'd31, 8'd12, 8'd99);
      wait_until_drained();

      // binary, 24-hour, offsets at the positive end of their encodings
      apply_settings(7'd0, 7'd1, {2'b00, 5'h0F}, 7'h3F);
      push_snapshot(8'd59, 8'd59, 8'd23, 8'd7, 8'd31, 8'd12, 8'd99);
      push_snapshot(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd0);

      // random phases, each starting from a fully drained block
      for (p = 0; p < RANDOM_PHASES; p++) begin
         wait_until_drained();
         apply_random_settings();
         for (i = 0; i < ITEMS_PER_PHASE; i++)
            pending_snapshots.push_back(gen_snapshot());
      end
      wait_until_drained();

      $display("checked %0d results from %0d transactions under %0d register settings",
               results_checked, items_accepted, settings_count);
      $display("directed calendar and 12-hour edge cases, then %0d random snapshot phases",
               RANDOM_PHASES);
      if (mismatch_count == 0 && expected_local_times.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[rtc_local_time_convert_core.f]
hw/rtl/rltc_pkg.sv
hw/rtl/rltc_front.sv
hw/rtl/rltc_queue.sv
hw/rtl/rltc_back.sv
hw/rtl/rtc_local_time_convert_core.sv
dv/tb_rtc_local_time_convert_core.sv
